// ===== rtl/core/s256h_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hasher.
`timescale 1ns / 1ps
`default_nettype none

package s256h_pkg;

    // Input word kinds, carried on the slave tuser bit
    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_TAIL,
        ST_PAD_BODY,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    // What the running compression belongs to
    typedef enum logic [1:0] {
        PH_DATA,
        PH_TAIL,
        PH_FINAL
    } phase_t;

    typedef struct packed {
        logic wr_data;
        logic pad_start;
        logic wr_pad;
        logic pad_len;
        logic comp_load;
        logic comp_round;
        logic comp_add;
        logic emit_load;
        logic restart;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
        logic [5:0] pad_pos;
        logic       rnd_last;
        logic       out_free;
        logic       emit_last;
    } dp_stat_t;

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
                                       input logic [31:0] g);
        ch = (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
        maj = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/s256h_ctrl.sv =====
// Sequencer for absorb, padding, compression rounds and digest output.
`timescale 1ns / 1ps
`default_nettype none

module s256h_ctrl
    import s256h_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_cmd,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_DATA;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        in_ready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == CMD_FINISH)
                    begin
                        cmd.pad_start = 1'b1;
                        if (stat.pos == 6'd63)
                        begin
                            // marker fills the block: compress, length goes in a new one
                            state_next = ST_LOAD;
                            phase_next = PH_TAIL;
                        end
                        else if (stat.pos >= 6'd56)
                        begin
                            state_next = ST_PAD_TAIL;
                            phase_next = PH_TAIL;
                        end
                        else
                        begin
                            state_next = ST_PAD_BODY;
                            phase_next = PH_FINAL;
                        end
                    end
                    else
                    begin
                        cmd.wr_data = 1'b1;
                        if (stat.pos == 6'd63)
                        begin
                            state_next = ST_LOAD;
                            phase_next = PH_DATA;
                        end
                    end
                end
            end
            ST_PAD_TAIL:
            begin
                cmd.wr_pad = 1'b1;
                if (stat.pad_pos == 6'd63)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_PAD_BODY:
            begin
                cmd.wr_pad  = 1'b1;
                cmd.pad_len = (stat.pad_pos[5:3] == 3'b111);
                if (stat.pad_pos == 6'd63)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.comp_load = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.comp_round = 1'b1;
                if (stat.rnd_last)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.comp_add = 1'b1;
                unique case (phase_reg)
                    PH_DATA:  state_next = ST_IDLE;
                    PH_TAIL:
                    begin
                        state_next = ST_PAD_BODY;
                        phase_next = PH_FINAL;
                    end
                    PH_FINAL: state_next = ST_EMIT;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (stat.emit_last)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hash add only ever follows the last round
    a_add_after_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> ($past(state_reg) == ST_ROUND))
        else $error("hash add without preceding round");

    // a compression starts only on a completely written block
    a_load_block_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |->
            ((phase_reg == PH_DATA && stat.pos == 6'd0) ||
             (phase_reg != PH_DATA && stat.pad_pos == 6'd0)))
        else $error("compression started on a partly written block");

endmodule

`default_nettype wire

// ===== rtl/core/s256h_dp.sv =====
// Datapath: block store / schedule window, round logic, hash words, output register.
`timescale 1ns / 1ps
`default_nettype none

module s256h_dp
    import s256h_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    input  wire logic [7:0]  data_byte,
    input  wire logic        out_ready,
    output dp_stat_t         stat,
    output logic [31:0]      out_word,
    output logic [2:0]       out_index,
    output logic             out_last,
    output logic             out_valid
);

    // The block store doubles as the 16-word schedule window during rounds
    logic [3:0][7:0] w_reg [16];
    logic [3:0][7:0] w_next [16];
    logic [31:0]     s_reg [8];
    logic [31:0]     s_next [8];
    logic [31:0]     h_reg [8];
    logic [31:0]     h_next [8];
    logic [63:0]     byte_count_reg, byte_count_next;
    logic [7:0][7:0] len_reg, len_next;
    logic [5:0]      pad_pos_reg, pad_pos_next;
    logic [5:0]      rnd_reg, rnd_next;
    logic [2:0]      emit_idx_reg, emit_idx_next;
    logic [31:0]     out_word_reg, out_word_next;
    logic [2:0]      out_idx_reg, out_idx_next;
    logic            out_valid_reg, out_valid_next;

    logic [5:0]  wr_addr;
    logic [7:0]  wr_byte;
    logic        wr_en;
    logic [31:0] t1, t2, w_new;

    always_comb
    begin
        wr_en   = cmd.wr_data | cmd.pad_start | cmd.wr_pad;
        wr_addr = cmd.wr_pad ? pad_pos_reg : byte_count_reg[5:0];
        priority if (cmd.wr_data)
            wr_byte = data_byte;
        else if (cmd.pad_start)
            wr_byte = PAD_MARK;
        else if (cmd.pad_len)
            wr_byte = len_reg[3'd7 - pad_pos_reg[2:0]];
        else
            wr_byte = 8'h00;

        t1 = s_reg[7] + bsig1(s_reg[4]) + ch(s_reg[4], s_reg[5], s_reg[6])
             + ROUND_K[rnd_reg] + w_reg[0];
        t2 = bsig0(s_reg[0]) + maj(s_reg[0], s_reg[1], s_reg[2]);
        w_new = ssig1(w_reg[14]) + w_reg[9] + ssig0(w_reg[1]) + w_reg[0];
    end

    always_comb
    begin
        w_next          = w_reg;
        s_next          = s_reg;
        h_next          = h_reg;
        byte_count_next = byte_count_reg;
        len_next        = len_reg;
        pad_pos_next    = pad_pos_reg;
        rnd_next        = rnd_reg;
        emit_idx_next   = emit_idx_reg;
        out_word_next   = out_word_reg;
        out_idx_next    = out_idx_reg;
        out_valid_next  = out_valid_reg;

        if (wr_en)
        begin
            w_next[wr_addr[5:2]][2'd3 - wr_addr[1:0]] = wr_byte;
        end
        if (cmd.wr_data)
        begin
            byte_count_next = byte_count_reg + 64'd1;
        end
        if (cmd.pad_start)
        begin
            len_next        = {byte_count_reg[60:0], 3'b000};
            byte_count_next = '0;
            pad_pos_next    = byte_count_reg[5:0] + 6'd1;
        end
        if (cmd.wr_pad)
        begin
            pad_pos_next = pad_pos_reg + 6'd1;
        end
        if (cmd.comp_load)
        begin
            s_next   = h_reg;
            rnd_next = '0;
        end
        if (cmd.comp_round)
        begin
            for (int j = 0; j < 15; j++)
            begin
                w_next[j] = w_reg[j + 1];
            end
            w_next[15] = w_new;
            s_next[7]  = s_reg[6];
            s_next[6]  = s_reg[5];
            s_next[5]  = s_reg[4];
            s_next[4]  = s_reg[3] + t1;
            s_next[3]  = s_reg[2];
            s_next[2]  = s_reg[1];
            s_next[1]  = s_reg[0];
            s_next[0]  = t1 + t2;
            rnd_next   = rnd_reg + 6'd1;
        end
        if (cmd.comp_add)
        begin
            for (int j = 0; j < 8; j++)
            begin
                h_next[j] = h_reg[j] + s_reg[j];
            end
        end
        if (cmd.emit_load)
        begin
            out_word_next  = h_reg[emit_idx_reg];
            out_idx_next   = emit_idx_reg;
            out_valid_next = 1'b1;
            emit_idx_next  = emit_idx_reg + 3'd1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.restart)
        begin
            h_next = H_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg          <= H_INIT;
            byte_count_reg <= '0;
            pad_pos_reg    <= '0;
            rnd_reg        <= '0;
            emit_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            h_reg          <= h_next;
            byte_count_reg <= byte_count_next;
            pad_pos_reg    <= pad_pos_next;
            rnd_reg        <= rnd_next;
            emit_idx_reg   <= emit_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        s_reg        <= s_next;
        len_reg      <= len_next;
        out_word_reg <= out_word_next;
        out_idx_reg  <= out_idx_next;
    end

    always_comb
    begin
        stat.pos       = byte_count_reg[5:0];
        stat.pad_pos   = pad_pos_reg;
        stat.rnd_last  = (rnd_reg == 6'd63);
        stat.out_free  = !out_valid_reg || out_ready;
        stat.emit_last = (emit_idx_reg == 3'd7);
    end

    assign out_word  = out_word_reg;
    assign out_index = out_idx_reg;
    assign out_last  = (out_idx_reg == 3'd7);
    assign out_valid = out_valid_reg;

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_data, cmd.pad_start, cmd.wr_pad, cmd.comp_load,
                  cmd.comp_round, cmd.comp_add, cmd.emit_load}))
        else $error("more than one datapath operation in a cycle");

    // never overwrite a digest word that is still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    a_restart_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.restart |-> (cmd.emit_load && emit_idx_reg == 3'd7))
        else $error("hash restart before the last digest word");

endmodule

`default_nettype wire

// ===== rtl/core/sha256_stream_hasher_core.sv =====
// Top level of the SHA-256 stream hasher: byte stream in, digest words out.
// Absorb: the byte that fills a block starts its compression
//   (load, 64 rounds at one round per cycle, hash add).
// Input bytes are not taken while a block is compressed; s_tready is high only when idle.
// Finish: the pad marker, zero padding and the length are written into the block,
//   one or two compressions, then 8 output words;
//   input is taken again once the last word sits in the output register.
// Reset (rst_n low, async): hash words to the initial values, byte count to zero, idle.
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hasher_core
    import s256h_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input word stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] cmd: 0 absorb byte, 1 finish message
    // digest word stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic             m_tlast    // last_word: set on digest word 7
);

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [31:0] out_word;
    logic [2:0]  out_index;

    // Controller: walks absorb, padding, the 64 rounds and the output of the digest
    s256h_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: block store (also the schedule window), rounds, hash words, output word
    s256h_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (s_tdata),
        .out_ready (m_tready),
        .stat      (stat),
        .out_word  (out_word),
        .out_index (out_index),
        .out_last  (m_tlast),
        .out_valid (m_tvalid)
    );

    assign m_tdata = {5'b00000, out_index, out_word};

endmodule

`default_nettype wire

// ===== tb/tb_sha256_stream_hasher_core.sv =====
// Self-checking testbench for the SHA-256 stream hasher core.
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_core;
    import s256h_pkg::*;

    localparam int RAND_WORDS  = 120;  // random input words to queue
    localparam int PHASE_WORDS = 24;   // input words per idling phase
    localparam int HOLD_AT     = 1;    // receiver hold starts after this many input words
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    // Round constants and initial hash value, kept apart from the design's copy
    localparam logic [31:0] SHA_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    typedef struct {
        logic       cmd;
        logic [7:0] byte_val;
        bit         wait_drain;   // hold this word back until no digest is outstanding
    } msg_word_t;

    typedef struct {
        logic [31:0] value;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    // Predicted hasher state
    logic [31:0] hash_state [8];
    logic [7:0]  blk_bytes [64];
    logic [63:0] msg_len;

    msg_word_t    msg_words [$];
    digest_word_t digest_due [$];

    int  words_total;
    int  words_in;
    int  fail_count;
    bit  word_taken;
    int  hold_cnt;
    bit  hold_done;

    sha256_stream_hasher_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] s [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
                   (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        s = hash_state;
        for (int i = 0; i < 64; i++)
        begin
            t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25)) +
                 ((s[4] & s[5]) ^ (~s[4] & s[6])) + SHA_K[i] + w[i];
            t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22)) +
                 ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
            s[7] = s[6];
            s[6] = s[5];
            s[5] = s[4];
            s[4] = s[3] + t1;
            s[3] = s[2];
            s[2] = s[1];
            s[1] = s[0];
            s[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] = hash_state[i] + s[i];
    endtask

    // One accepted input word: absorb a byte, or pad, compress and queue the digest
    task automatic hash_word(input logic cmd, input logic [7:0] data);
        logic [63:0]  bit_len;
        int           p;
        digest_word_t d;
        if (cmd == CMD_ABSORB)
        begin
            blk_bytes[msg_len[5:0]] = data;
            msg_len = msg_len + 64'd1;
            if (msg_len[5:0] == 6'd0)
                compress_block();
        end
        else
        begin
            bit_len = msg_len << 3;
            p = int'(msg_len[5:0]);
            blk_bytes[p] = PAD_MARK;
            p = p + 1;
            // length field does not fit: spill into one more block
            if (p > 56)
            begin
                while (p < 64)
                begin
                    blk_bytes[p] = 8'h00;
                    p = p + 1;
                end
                compress_block();
                p = 0;
            end
            while (p < 56)
            begin
                blk_bytes[p] = 8'h00;
                p = p + 1;
            end
            for (int i = 0; i < 8; i++)
                blk_bytes[56 + i] = bit_len[63 - 8*i -: 8];
            compress_block();
            for (int i = 0; i < 8; i++)
            begin
                d.value = hash_state[i];
                d.index = i[2:0];
                d.last  = (i == 7);
                digest_due.push_back(d);
            end
            hash_state = SHA_IV;
            msg_len = 64'd0;
        end
    endtask

    function automatic void log_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endfunction

    task automatic add_word(input logic cmd, input logic [7:0] data, input bit drain);
        msg_word_t w;
        w.cmd = cmd;
        w.byte_val = data;
        w.wait_drain = drain;
        msg_words.push_back(w);
    endtask

    task automatic add_message(input int len, input bit drain);
        for (int i = 0; i < len; i++)
            add_word(CMD_ABSORB, 8'($urandom_range(0, 255)), drain && (i == 0));
        add_word(CMD_FINISH, 8'($urandom_range(0, 255)), drain && (len == 0));
    endtask

    // Monitor: digest words checked against prediction, accepted input fed to the model
    always @(posedge clk)
    begin : monitor
        digest_word_t d;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (digest_due.size() == 0)
                    log_failure($sformatf("unexpected digest word data=%h last=%b",
                                          m_tdata, m_tlast));
                else
                begin
                    d = digest_due.pop_front();
                    if (m_tdata !== {5'b0, d.index, d.value} || m_tlast !== d.last)
                        log_failure($sformatf("digest word: exp data=%h last=%b, got data=%h last=%b",
                                              {5'b0, d.index, d.value}, d.last, m_tdata, m_tlast));
                end
            end
            if (s_tvalid && s_tready)
            begin
                hash_word(s_tuser, s_tdata);
                words_in++;
                word_taken = 1'b1;
            end
        end
    end

    // Long receiver hold-off early on, so the core backs up and stalls its input
    always @(negedge clk)
    begin : rx_hold
        if (!hold_done && words_in == HOLD_AT)
        begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    // Input word driver
    always @(negedge clk)
    begin : driver
        msg_word_t w;
        logic      go;
        int        idle_pct;
        case ((words_in / PHASE_WORDS) % 4)
            1:       idle_pct = 80;
            3:       idle_pct = 13;
            default: idle_pct = 0;
        endcase
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!(s_tvalid && !word_taken))
        begin
            word_taken = 1'b0;
            go = (msg_words.size() != 0);
            if (go && msg_words[0].wait_drain && digest_due.size() != 0)
                go = 1'b0;
            if (go && hold_cnt == 0 && $urandom_range(0, 99) < idle_pct)
                go = 1'b0;
            if (go)
            begin
                w = msg_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= w.byte_val;
                s_tuser  <= w.cmd;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Digest receiver
    always @(negedge clk)
    begin : receiver
        int stall_pct;
        case ((words_in / PHASE_WORDS) % 4)
            2:       stall_pct = 80;
            3:       stall_pct = 13;
            default: stall_pct = 0;
        endcase
        if (hold_cnt != 0)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial
    begin : stimulus
        int pick;
        int len;
        int rnd_base;
        int msg_no;
        int room;
        hash_state = SHA_IV;
        msg_len    = 64'd0;
        for (int i = 0; i < 64; i++)
            blk_bytes[i] = 8'h00;

        // empty message, then a finish whose data byte must be ignored
        add_word(CMD_FINISH, 8'h00, 1'b0);
        add_word(CMD_FINISH, 8'hFF, 1'b0);
        // "abc", sent only once both empty digests are out
        add_word(CMD_ABSORB, 8'h61, 1'b1);
        add_word(CMD_ABSORB, 8'h62, 1'b0);
        add_word(CMD_ABSORB, 8'h63, 1'b0);
        add_word(CMD_FINISH, 8'h00, 1'b0);
        // byte extremes and a byte equal to the pad marker
        add_word(CMD_ABSORB, 8'h00, 1'b0);
        add_word(CMD_ABSORB, 8'hFF, 1'b0);
        add_word(CMD_ABSORB, PAD_MARK, 1'b0);
        add_word(CMD_FINISH, 8'h5A, 1'b0);

        // Random messages; the first forces the extra length block
        rnd_base = msg_words.size();
        msg_no = 0;
        while (msg_words.size() - rnd_base < RAND_WORDS)
        begin
            // bytes left for this message once its finish word is set aside
            room = RAND_WORDS - (msg_words.size() - rnd_base) - 1;
            pick = $urandom_range(0, 9);
            if (msg_no == 0)
                len = 56;
            else if (pick < 6)
                len = $urandom_range(0, 12);
            else if (pick < 9)
                len = $urandom_range(52, 66);
            else
                len = 0;
            if (msg_no != 0 && len > room)
                len = room;
            add_message(len, msg_no == 0);
            msg_no++;
        end
        words_total = msg_words.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_in != words_total || digest_due.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/s256h_pkg.sv
rtl/core/s256h_ctrl.sv
rtl/core/s256h_dp.sv
rtl/core/sha256_stream_hasher_core.sv
tb/tb_sha256_stream_hasher_core.sv
